// File: rtl/core/oli_pkg.sv
// Shared constants and types for the ordered list block.
package oli_pkg;

   localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
   localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
   localparam logic [2:0] KIND_INSERT_AT  = 3'd2;
   localparam logic [2:0] KIND_REMOVE_AT  = 3'd3;
   localparam logic [2:0] KIND_REMOVE_VAL = 3'd4;
   localparam logic [2:0] KIND_FIND_VAL   = 3'd5;
   localparam logic [2:0] KIND_READ_AT    = 3'd6;
   localparam logic [2:0] KIND_UNUSED     = 3'd7;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_BADPOS   = 3'd1;
   localparam logic [2:0] ST_EMPTY    = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOTFOUND = 3'd4;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // capture request and search the cells
      logic ins;       // open a gap at the target and write the value
      logic rem;       // close the gap at the target
      logic use_match; // target is the first matching cell
      logic respond;   // drive the result strobe
   } oli_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic [2:0] kind;
      logic       empty;
      logic       full;
      logic       pos_gt;  // position above count
      logic       pos_ge;  // position at or above count
      logic       hit;     // some stored cell equals the value
   } oli_stat_type;

endpackage

// File: rtl/core/oli_datapath.sv
// Cell chain, count, match search and result registers.
module oli_datapath import oli_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  oli_cmd_type                    cmd,
   input  logic [2:0]                     req_kind,
   input  logic [$clog2(CAPACITY+1)-1:0]  req_position,
   input  logic signed [31:0]             req_value,
   input  logic [2:0]                     rsp_status_in,
   output oli_stat_type                   stat,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_status,
   output logic signed [31:0]             rsp_data_out,
   output logic [$clog2(CAPACITY)-1:0]    rsp_found_index,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_item_count
);
   localparam int IW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY+1);

   logic [31:0]   cell_ff [CAPACITY];
   logic [CW-1:0] count_ff, count_in;
   logic [2:0]    kind_ff;
   logic [CW-1:0] pos_ff;
   logic [31:0]   val_ff;
   logic [CAPACITY-1:0] match_in;
   logic [IW-1:0] first_ff, first_in;
   logic          hit_ff;
   logic [CW-1:0] tgt;
   logic [31:0]   tgt_data;
   logic          valid_ff;
   logic [2:0]    status_ff;
   logic [31:0]   data_ff;
   logic [IW-1:0] fidx_ff;
   logic          ok;

   // equality per cell, only below the count
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (cell_ff[i] == req_value) && (CW'(i) < count_ff);
      end
      first_in = '0;
      for (int i = CAPACITY-1; i >= 0; i--) begin
         if (match_in[i]) first_in = IW'(i);
      end
   end

   always_comb begin
      if (cmd.use_match) tgt = CW'(first_ff);
      else if (kind_ff == KIND_PUSH_FRONT) tgt = '0;
      else if (kind_ff == KIND_PUSH_BACK) tgt = count_ff;
      else tgt = pos_ff;
      tgt_data = cell_ff[tgt[IW-1:0]];
   end

   assign ok = (rsp_status_in == ST_OK);

   always_comb begin
      count_in = count_ff;
      if (cmd.ins && ok) count_in = count_ff + CW'(1);
      else if (cmd.rem && ok) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         pos_ff   <= req_position;
         val_ff   <= req_value;
         first_ff <= first_in;
         hit_ff   <= |match_in;
      end
      for (int i = 0; i < CAPACITY; i++) begin
         if (cmd.ins && ok) begin
            if (CW'(i) == tgt) cell_ff[i] <= val_ff;
            else if (CW'(i) > tgt && i > 0) cell_ff[i] <= cell_ff[(i > 0) ? i-1 : 0];
         end else if (cmd.rem && ok) begin
            if (CW'(i) >= tgt && i < CAPACITY-1)
               cell_ff[i] <= cell_ff[(i < CAPACITY-1) ? i+1 : i];
         end
      end
      if (cmd.respond) begin
         status_ff <= rsp_status_in;
         data_ff   <= (ok && (cmd.rem || kind_ff == KIND_READ_AT)) ? tgt_data : '0;
         fidx_ff   <= (ok && cmd.use_match) ? first_ff : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= cmd.respond;
      end
   end

   assign stat.kind   = kind_ff;
   assign stat.empty  = (count_ff == '0);
   assign stat.full   = (count_ff >= CW'(CAPACITY));
   assign stat.pos_gt = (pos_ff > count_ff);
   assign stat.pos_ge = (pos_ff >= count_ff);
   assign stat.hit    = hit_ff;

   assign rsp_valid       = valid_ff;
   assign rsp_status      = status_ff;
   assign rsp_data_out    = data_ff;
   assign rsp_found_index = fidx_ff;
   assign rsp_item_count  = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY)) else $error("count above capacity");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !cmd.ins && !cmd.rem |=> $stable(count_ff)) else $error("count moved without command");
   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.ins && cmd.rem)) else $error("insert and remove together");
endmodule

// File: rtl/core/oli_ctrl.sv
// Request sequencer: capture, then execute and answer.
module oli_ctrl import oli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  oli_stat_type stat,
   output oli_cmd_type  cmd,
   output logic [2:0]   status
);
   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff, state_in;

   always_comb begin
      cmd = '0;
      status = ST_OK;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load = start;
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            cmd.respond = 1'b1;
            state_in = S_IDLE;
            unique case (stat.kind)
               KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
                  cmd.ins = 1'b1;
                  if (stat.full) status = ST_FULL;
               end
               KIND_INSERT_AT: begin
                  cmd.ins = 1'b1;
                  if (stat.pos_gt) status = ST_BADPOS;
                  else if (stat.full) status = ST_FULL;
               end
               KIND_REMOVE_AT: begin
                  cmd.rem = 1'b1;
                  if (stat.empty) status = ST_EMPTY;
                  else if (stat.pos_ge) status = ST_BADPOS;
               end
               KIND_REMOVE_VAL: begin
                  cmd.rem = 1'b1;
                  cmd.use_match = 1'b1;
                  if (stat.empty) status = ST_EMPTY;
                  else if (!stat.hit) status = ST_NOTFOUND;
               end
               KIND_FIND_VAL: begin
                  cmd.use_match = 1'b1;
                  if (!stat.hit) status = ST_NOTFOUND;
               end
               KIND_READ_AT: begin
                  if (stat.empty) status = ST_EMPTY;
                  else if (stat.pos_ge) status = ST_BADPOS;
               end
               default: ;
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   assign busy = (state_ff == S_EXEC);

   a_resp_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.respond) else $error("load without answer");
   a_no_load_busy: assert property (@(posedge clock) disable iff (reset)
      busy |-> !cmd.load) else $error("load while busy");
   a_resp_once: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !cmd.respond) else $error("double answer");
endmodule

// File: rtl/core/ordered_list_insert_remove_top.sv
// Top level of the bounded ordered list.
// Each request runs as a capture step and an execute step: the request cycle registers it
// and compares the value against every stored cell at once, the next cycle shifts the cell
// chain and registers the answer; busy is high for that execute cycle. The result appears
// on the rsp_ ports with rsp_valid high for one cycle, registered from the execute cycle,
// and the receiver cannot stall it. A new request is taken only while busy is low.
module ordered_list_insert_remove_top import oli_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [2:0]                     req_kind,
   input  logic [$clog2(CAPACITY+1)-1:0]  req_position,
   input  logic signed [31:0]             req_value,
   output logic                           rsp_valid,
   output logic [2:0]                     rsp_status,
   output logic signed [31:0]             rsp_data_out,
   output logic [$clog2(CAPACITY)-1:0]    rsp_found_index,
   output logic [$clog2(CAPACITY+1)-1:0]  rsp_item_count
);
   oli_cmd_type  cmd;
   oli_stat_type stat;
   logic [2:0]   status;

   oli_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd), .status(status)
   );

   oli_datapath #(.CAPACITY(CAPACITY)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_kind(req_kind), .req_position(req_position), .req_value(req_value),
      .rsp_status_in(status), .stat(stat),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_data_out(rsp_data_out),
      .rsp_found_index(rsp_found_index), .rsp_item_count(rsp_item_count)
   );
endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the bounded ordered list: directed and random requests.
module tb;
   import oli_pkg::*;

   localparam int CAP = 16;
   localparam int LIMIT_CYCLES = 200000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [2:0] req_kind = '0;
   logic [4:0] req_position = '0;
   logic signed [31:0] req_value = '0;
   logic rsp_valid;
   logic [2:0] rsp_status;
   logic signed [31:0] rsp_data_out;
   logic [3:0] rsp_found_index;
   logic [4:0] rsp_item_count;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] data;
      logic [3:0]  fidx;
      logic [4:0]  count;
   } answer_type;

   answer_type answer_q[$];
   logic [31:0] cells[CAP];
   int unsigned list_len = 0;
   int errors = 0;
   int cycles = 0;

   ordered_list_insert_remove_top #(.CAPACITY(CAP)) u_top (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("tb: failure");
         $finish;
      end
   end

   // work out the answer of one request and update the list copy
   function automatic answer_type predict_list(logic [2:0] kind, int unsigned pos,
                                               logic [31:0] val);
      answer_type a;
      int unsigned at;
      int hit;
      bit ins;
      a = '0;
      at = 0;
      hit = -1;
      ins = 0;
      for (int i = list_len - 1; i >= 0; i--)
         if (cells[i] == val) hit = i;
      case (kind)
         KIND_PUSH_FRONT: begin at = 0; ins = 1; end
         KIND_PUSH_BACK: begin at = list_len; ins = 1; end
         KIND_INSERT_AT: begin
            if (pos > list_len) a.status = ST_BADPOS;
            else begin at = pos; ins = 1; end
         end
         KIND_REMOVE_AT, KIND_READ_AT: begin
            if (list_len == 0) a.status = ST_EMPTY;
            else if (pos >= list_len) a.status = ST_BADPOS;
            else begin
               a.data = cells[pos];
               if (kind == KIND_REMOVE_AT) begin
                  for (int i = pos; i + 1 < list_len; i++) cells[i] = cells[i + 1];
                  list_len--;
               end
            end
         end
         KIND_REMOVE_VAL: begin
            if (list_len == 0) a.status = ST_EMPTY;
            else if (hit < 0) a.status = ST_NOTFOUND;
            else begin
               a.data = cells[hit];
               a.fidx = 4'(hit);
               for (int i = hit; i + 1 < list_len; i++) cells[i] = cells[i + 1];
               list_len--;
            end
         end
         KIND_FIND_VAL: begin
            if (hit < 0) a.status = ST_NOTFOUND;
            else a.fidx = 4'(hit);
         end
         default: ;
      endcase
      if (ins) begin
         if (list_len >= CAP) a.status = ST_FULL;
         else begin
            for (int i = list_len; i > at; i--) cells[i] = cells[i - 1];
            cells[at] = val;
            list_len++;
         end
      end
      a.count = 5'(list_len);
      return a;
   endfunction

   // check every result transfer against the oldest expectation
   always @(posedge clock) begin
      answer_type exp_a;
      if (!reset && rsp_valid) begin
         if (answer_q.size() == 0) begin
            $display("%0t: unexpected result status %0d", $time, rsp_status);
            errors++;
         end else begin
            exp_a = answer_q.pop_front();
            if (rsp_status !== exp_a.status) begin
               $display("%0t: status exp %0d got %0d", $time, exp_a.status, rsp_status);
               errors++;
            end
            if (rsp_data_out !== exp_a.data) begin
               $display("%0t: data_out exp %0h got %0h", $time, exp_a.data, rsp_data_out);
               errors++;
            end
            if (rsp_found_index !== exp_a.fidx) begin
               $display("%0t: found_index exp %0d got %0d", $time, exp_a.fidx,
                        rsp_found_index);
               errors++;
            end
            if (rsp_item_count !== exp_a.count) begin
               $display("%0t: item_count exp %0d got %0d", $time, exp_a.count,
                        rsp_item_count);
               errors++;
            end
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) n = 0;
      if (n > 0) begin
         start <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   // drive one request and wait for its transfer
   task automatic send_request(logic [2:0] kind, logic [4:0] pos, logic [31:0] val,
                               bit gaps = 1);
      start <= 1;
      req_kind <= kind;
      req_position <= pos;
      req_value <= val;
      @(posedge clock);
      while (busy) @(posedge clock);
      answer_q.push_back(predict_list(kind, pos, val));
      if (gaps && $urandom_range(0, 1)) idle_gap();
   endtask

   task automatic drain();
      if (answer_q.size() != 0) begin
         start <= 0;
         while (answer_q.size() != 0) @(posedge clock);
      end
   endtask

   task automatic test_directed();
      send_request(KIND_REMOVE_AT, 0, 0);
      send_request(KIND_READ_AT, 0, 0);
      send_request(KIND_REMOVE_VAL, 0, 5);
      send_request(KIND_FIND_VAL, 0, 5);
      send_request(KIND_INSERT_AT, 1, 7);
      send_request(KIND_PUSH_BACK, 0, 32'h8000_0000);
      send_request(KIND_PUSH_FRONT, 0, 32'h7fff_ffff);
      send_request(KIND_INSERT_AT, 1, 32'hffff_ffff);
      send_request(KIND_READ_AT, 3, 0);
      send_request(KIND_READ_AT, 2, 0);
      send_request(KIND_FIND_VAL, 0, 32'hffff_ffff);
      send_request(KIND_REMOVE_VAL, 0, 1);
      send_request(KIND_UNUSED, 31, 32'h5555_aaaa);
      for (int i = 0; i < 14; i++) send_request(KIND_PUSH_BACK, 0, i);
      send_request(KIND_PUSH_FRONT, 0, 99);
      send_request(KIND_INSERT_AT, 16, 99);
      send_request(KIND_INSERT_AT, 17, 99);
      send_request(KIND_REMOVE_AT, 16, 0);
      send_request(KIND_REMOVE_AT, 15, 0);
      send_request(KIND_REMOVE_VAL, 0, 32'h7fff_ffff);
      send_request(KIND_INSERT_AT, 14, 1);
   endtask

   task automatic test_random();
      logic [2:0] kind;
      logic [4:0] pos;
      logic [31:0] val;
      for (int n = 0; n < 1120; n++) begin
         kind = 3'($urandom_range(0, 7));
         pos = ($urandom_range(0, 7) == 0) ? 5'($urandom_range(0, 31))
                                          : 5'($urandom_range(0, list_len));
         // small pool so finds and removes by value often hit
         if ($urandom_range(0, 2) == 0) val = $urandom();
         else if (list_len != 0 && $urandom_range(0, 1))
            val = cells[$urandom_range(0, list_len - 1)];
         else val = $urandom_range(0, 7) - 4;
         if (n == 560) drain();
         send_request(kind, pos, val, n % 200 < 150);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      test_directed();
      drain();
      test_random();
      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule
